>>> src/sbsr_pkg.sv
// Shared types and codes of the status byte and summary register block.
// Used by sbsr_regfile and status_byte_summary_registers_core; no dependencies.
package sbsr_pkg;

  // Default register width
  localparam int REG_WIDTH_DEF = 16;

  // Command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_SET    = 3'd2;
  localparam logic [2:0] CMD_CLR    = 3'd3;
  localparam logic [2:0] CMD_RDCLR  = 3'd4;
  localparam logic [2:0] CMD_CLS    = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_STB  = 3'd0;  // status byte
  localparam logic [2:0] REG_SRE  = 3'd1;  // service request enable
  localparam logic [2:0] REG_ESR  = 3'd2;  // standard event status
  localparam logic [2:0] REG_ESE  = 3'd3;  // standard event enable
  localparam logic [2:0] REG_QUES = 3'd4;  // questionable event
  localparam logic [2:0] REG_QUEN = 3'd5;  // questionable enable
  localparam logic [2:0] REG_OPER = 3'd6;  // operation event
  localparam logic [2:0] REG_OPEN = 3'd7;  // operation enable

  // Summary bit positions in the status byte
  localparam int BIT_QUES = 3;
  localparam int BIT_EVT  = 5;
  localparam int BIT_RQS  = 6;
  localparam int BIT_OPER = 7;

  // One command word
  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  reg_index;
    logic [2:0]  command;
  } req_t;

  // One result word
  typedef struct packed {
    logic        service_request;
    logic [15:0] read_data;
  } resp_t;

endpackage

>>> src/sbsr_regfile.sv
// Eight status registers with the summary and service request update logic.
// Depends on sbsr_pkg for command codes, register indexes and word types.
module sbsr_regfile import sbsr_pkg::*; #(
  parameter int REG_WIDTH = REG_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  upd_en,
  input  req_t  req,
  output resp_t resp
);

  localparam logic [REG_WIDTH-1:0] RQS_MASK =
    {{(REG_WIDTH-1){1'b0}}, 1'b1} << BIT_RQS;

  logic [7:0][REG_WIDTH-1:0]  regs_r;
  logic [7:0][REG_WIDTH-1:0]  regs_nxt;
  logic [REG_WIDTH+15:0]      val_ext;
  logic [REG_WIDTH-1:0]       val_w;
  logic [REG_WIDTH-1:0]       cur;
  logic [REG_WIDTH+15:0]      rd_ext;
  logic [REG_WIDTH-1:0]       wr_val;
  logic [REG_WIDTH-1:0]       sb;
  logic                       wr_single;
  logic                       cls;
  logic                       rd_sel;

  // Fit the 16-bit data to the register width
  assign val_ext = {{REG_WIDTH{1'b0}}, req.value};
  assign val_w   = val_ext[REG_WIDTH-1:0];
  assign cur     = regs_r[req.reg_index];
  assign rd_ext  = {16'd0, cur};

  // Decode the command and build the next register contents
  always_comb begin
    wr_single = 1'b0;
    cls       = 1'b0;
    wr_val    = '0;
    case (req.command)
      CMD_READ: begin
      end
      CMD_WRITE: begin
        wr_single = 1'b1;
        wr_val    = val_w;
      end
      CMD_SET: begin
        wr_single = 1'b1;
        wr_val    = cur | val_w;
      end
      CMD_CLR: begin
        wr_single = 1'b1;
        wr_val    = cur & ~val_w;
      end
      CMD_RDCLR: begin
        wr_single = 1'b1;
        wr_val    = '0;
      end
      CMD_CLS: begin
        cls = 1'b1;
      end
      default: begin
      end
    endcase
    rd_sel = (req.command == CMD_READ) || (req.command == CMD_RDCLR);

    regs_nxt = regs_r;
    sb       = regs_r[REG_STB];
    if (wr_single) begin
      regs_nxt[req.reg_index] = wr_val;
      if (req.reg_index == REG_STB) begin
        sb = wr_val;
      end
    end
    if (cls) begin
      regs_nxt[REG_ESR]  = '0;
      regs_nxt[REG_QUES] = '0;
      regs_nxt[REG_OPER] = '0;
      sb[BIT_EVT]  = 1'b0;
      sb[BIT_QUES] = 1'b0;
      sb[BIT_OPER] = 1'b0;
    end

    // Refresh the summary of the pair that was written
    if (wr_single) begin
      case (req.reg_index)
        REG_ESR, REG_ESE: begin
          sb[BIT_EVT] = |(regs_nxt[REG_ESR] & regs_nxt[REG_ESE]);
        end
        REG_QUES, REG_QUEN: begin
          sb[BIT_QUES] = |(regs_nxt[REG_QUES] & regs_nxt[REG_QUEN]);
        end
        REG_OPER, REG_OPEN: begin
          sb[BIT_OPER] = |(regs_nxt[REG_OPER] & regs_nxt[REG_OPEN]);
        end
        default: begin
        end
      endcase
    end

    // Recompute the request bit on every write and on clear status
    if (wr_single || cls) begin
      sb[BIT_RQS] = |(sb & regs_nxt[REG_SRE] & ~RQS_MASK);
    end
    regs_nxt[REG_STB] = sb;
  end

  assign resp.read_data       = rd_sel ? rd_ext[15:0] : 16'd0;
  assign resp.service_request = regs_nxt[REG_STB][BIT_RQS];

  // Hold the registers, advance on each accepted command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (upd_en) begin
      regs_r <= regs_nxt;
    end
  end

  // Request bit always matches status byte AND request enable
  a_rqs_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    regs_r[REG_STB][BIT_RQS] == |(regs_r[REG_STB] & regs_r[REG_SRE] & ~RQS_MASK))
    else $error("request bit out of step with status byte and enable");

  // Clear status leaves all event registers empty
  a_cls_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && req.command == CMD_CLS |=>
      regs_r[REG_ESR] == '0 && regs_r[REG_QUES] == '0 && regs_r[REG_OPER] == '0)
    else $error("clear status left an event register set");

  // A plain read changes no register
  a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && req.command == CMD_READ |=> $stable(regs_r))
    else $error("read command modified a register");

endmodule

>>> src/status_byte_summary_registers_core.sv
// Top level of the status byte and summary register block: stream ports,
// command register and result register. Depends on sbsr_pkg and sbsr_regfile.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_tvalid/tready    | in_tdata: command, reg_index, value
//  out_    | output    | out_tvalid/tready   | out_tdata: read_data, service_request
//
// One command is accepted per cycle unless the input stalls; its result passes
// through the command register, then the result register after the update.
// The register update is combinational logic between those two registers.
// A stalled result holds the command register; input stalls only when both
// registers are full and the result is held. Reset clears all eight registers
// and the valid flags.
module status_byte_summary_registers_core import sbsr_pkg::*; #(
  parameter int REG_WIDTH = REG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [2:0] command, [5:3] reg_index, [21:6] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] read_data, [16] service_request
);

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  resp_t out_resp_r;
  resp_t resp;
  logic  advance;

  // Move the held command on when the result slot frees up
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  sbsr_regfile #(
    .REG_WIDTH (REG_WIDTH)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .req    (s1_req_r),
    .resp   (resp)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= req_t'(in_tdata[21:0]);
    end
    if (advance) begin
      out_resp_r <= resp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_resp_r};

endmodule

>>> sim/status_byte_summary_registers_core_test.sv
// Self-checking testbench for status_byte_summary_registers_core: directed table, then random
// command words under four idle/stall mixes, checked against a shadow register model
// (typed directed rows against their own result). Depends on sbsr_pkg and the RTL under src/.
module status_byte_summary_registers_core_test import sbsr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  // Summary and request masks in the status byte
  localparam logic [15:0] QUES_MASK = 16'(1) << BIT_QUES;
  localparam logic [15:0] EVT_MASK  = 16'(1) << BIT_EVT;
  localparam logic [15:0] RQS_MASK  = 16'(1) << BIT_RQS;
  localparam logic [15:0] OPER_MASK = 16'(1) << BIT_OPER;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_CAP    = 10;
  localparam int PHASE_WORDS   = 200;
  localparam int DIRECTED_ROWS = 25;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [2:0] command, [5:3] reg_index, [21:6] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [15:0] read_data, [16] service_request

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Shadow copy of the eight registers and results still owed by the block
  logic [15:0] shadow_regs [8];
  resp_t       pending_resp [$];

  // Directed stimulus row; typed rows carry their expected result
  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  reg_index;
    logic [15:0] value;
    logic        typed;
    logic [15:0] rd;
    logic        srq;
  } stim_row_t;

  stim_row_t dir_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,    REG_STB,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{CMD_READ,    REG_OPEN, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_SRE,  16'hffff, 1'b1, 16'h0000, 1'b0},
    '{CMD_SET,     REG_ESE,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{CMD_SET,     REG_ESR,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{CMD_RDCLR,   REG_ESR,  16'h0000, 1'b1, 16'h0001, 1'b0},
    '{CMD_WRITE,   REG_QUEN, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_QUES, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_OPEN, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_OPER, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_CLR,     REG_OPER, 16'hfffe, 1'b0, 16'h0000, 1'b0},
    '{CMD_CLS,     REG_SRE,  16'h5a5a, 1'b1, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_STB,  16'hffff, 1'b1, 16'h0000, 1'b1},
    '{CMD_READ,    REG_STB,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_SRE,  16'h0040, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_ESE,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_SPARE_A, REG_ESE,  16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_SPARE_B, REG_OPEN, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_READ,    REG_STB,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_SET,     REG_SRE,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_CLR,     REG_SRE,  16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_RDCLR,   REG_STB,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_CLS,     REG_OPEN, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{CMD_READ,    REG_ESE,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{CMD_WRITE,   REG_OPEN, 16'hffff, 1'b0, 16'h0000, 1'b0}
  };

  status_byte_summary_registers_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store the status byte with the request bit rebuilt from the enable
  function automatic void post_status_byte(logic [15:0] v);
    if ((v & shadow_regs[REG_SRE] & ~RQS_MASK) != '0) v = v | RQS_MASK;
    else v = v & ~RQS_MASK;
    shadow_regs[REG_STB] = v;
  endfunction

  // Rebuild one summary bit from its event and enable pair
  function automatic void refresh_pair(logic [2:0] evt, logic [2:0] en, logic [15:0] mask);
    if ((shadow_regs[evt] & shadow_regs[en]) != '0)
      post_status_byte(shadow_regs[REG_STB] | mask);
    else
      post_status_byte(shadow_regs[REG_STB] & ~mask);
  endfunction

  function automatic void commit_reg(logic [2:0] r, logic [15:0] v);
    shadow_regs[r] = v;
    case (r)
      REG_STB: post_status_byte(v);
      REG_SRE: post_status_byte(shadow_regs[REG_STB]);
      REG_ESR, REG_ESE: refresh_pair(REG_ESR, REG_ESE, EVT_MASK);
      REG_QUES, REG_QUEN: refresh_pair(REG_QUES, REG_QUEN, QUES_MASK);
      default: refresh_pair(REG_OPER, REG_OPEN, OPER_MASK);
    endcase
  endfunction

  // Advance the shadow registers by one command word and return its result
  function automatic resp_t apply_command(req_t w);
    resp_t r;
    r = '0;
    case (w.command)
      CMD_READ: r.read_data = shadow_regs[w.reg_index];
      CMD_WRITE: commit_reg(w.reg_index, w.value);
      CMD_SET: commit_reg(w.reg_index, shadow_regs[w.reg_index] | w.value);
      CMD_CLR: commit_reg(w.reg_index, shadow_regs[w.reg_index] & ~w.value);
      CMD_RDCLR: begin
        r.read_data = shadow_regs[w.reg_index];
        commit_reg(w.reg_index, '0);
      end
      CMD_CLS: begin
        commit_reg(REG_ESR, '0);
        commit_reg(REG_OPER, '0);
        commit_reg(REG_QUES, '0);
      end
      default: ;
    endcase
    r.service_request = shadow_regs[REG_STB][BIT_RQS];
    return r;
  endfunction

  // Random command, leaning on writes so summary bits move often
  function automatic logic [2:0] pick_command();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 18) return CMD_READ;
    if (p < 40) return CMD_WRITE;
    if (p < 57) return CMD_SET;
    if (p < 72) return CMD_CLR;
    if (p < 87) return CMD_RDCLR;
    if (p < 94) return CMD_CLS;
    if (p < 97) return CMD_SPARE_A;
    return CMD_SPARE_B;
  endfunction

  function automatic logic [15:0] pick_value();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 16'($urandom);
    if (p < 60) return 16'(1) << $urandom_range(15);
    if (p < 72) return (QUES_MASK | EVT_MASK | OPER_MASK) & 16'($urandom);
    if (p < 84) return 16'($urandom_range(255));
    if (p < 92) return 16'hffff;
    return 16'h0000;
  endfunction

  // Offer one word after a random gap, then log its expected result on acceptance
  task automatic send_word(req_t w, logic typed, resp_t typed_resp);
    resp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, w};
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(w);
    pending_resp.push_back(typed ? typed_resp : predicted);
  endtask

  // Hold the input idle until every owed result is back
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("mismatch %s: expected %h, got %h at cycle %0d", what, want, got, cycles);
  endtask

  // Check accepted results and drive receiver stalls
  always @(posedge clk) begin : watch_out
    resp_t got;
    resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = resp_t'(out_tdata[16:0]);
      if (pending_resp.size() == 0) begin
        note_mismatch("unexpected result word", '0, got.read_data);
      end else begin
        want = pending_resp.pop_front();
        if (got.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, got.read_data);
        if (got.service_request !== want.service_request)
          note_mismatch("service_request", 16'(want.service_request), 16'(got.service_request));
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        w;
    resp_t       typed_resp;
    int unsigned phase_idle  [4];
    int unsigned phase_stall [4];
    phase_idle  = '{0, 84, 0, 27};
    phase_stall = '{0, 0, 84, 27};
    for (int i = 0; i < 8; i++) shadow_regs[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with no idling
    foreach (dir_rows[i]) begin
      w.command   = dir_rows[i].command;
      w.reg_index = dir_rows[i].reg_index;
      w.value     = dir_rows[i].value;
      typed_resp.read_data       = dir_rows[i].rd;
      typed_resp.service_request = dir_rows[i].srq;
      send_word(w, dir_rows[i].typed, typed_resp);
    end
    hold_until_drained();

    // Random words under each idle/stall mix, draining between mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w.command   = pick_command();
        w.reg_index = 3'($urandom_range(7));
        w.value     = pick_value();
        send_word(w, 1'b0, '0);
      end
      hold_until_drained();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
